// File: src/hppf_pkg.sv
package hppf_pkg;

  localparam int unsigned AddrW  = 32;
  localparam int unsigned PortW  = 16;
  localparam int unsigned ProtoW = 8;
  localparam int unsigned CountW = 3;
  localparam int unsigned CfgIdxW = 3;
  localparam int unsigned CfgDataW = 32;

  localparam logic [ProtoW-1:0] ProtoTcp = 8'd6;
  localparam logic [CountW-1:0] CountMax = 3'd7;

  // Register indexes of the configuration port.
  localparam logic [CfgIdxW-1:0] CfgIntHostA = 3'd0;
  localparam logic [CfgIdxW-1:0] CfgIntHostB = 3'd1;
  localparam logic [CfgIdxW-1:0] CfgIntHostC = 3'd2;
  localparam logic [CfgIdxW-1:0] CfgExtHostA = 3'd3;
  localparam logic [CfgIdxW-1:0] CfgExtHostB = 3'd4;
  localparam logic [CfgIdxW-1:0] CfgAllowPort = 3'd5;
  localparam logic [CfgIdxW-1:0] CfgSynLimit = 3'd6;

  // Reset values: 192.168.60.5/6/7, 10.9.0.5, 10.9.0.1, port 23, limit 3.
  localparam logic [AddrW-1:0]  RstIntHostA = 32'hC0A8_3C05;
  localparam logic [AddrW-1:0]  RstIntHostB = 32'hC0A8_3C06;
  localparam logic [AddrW-1:0]  RstIntHostC = 32'hC0A8_3C07;
  localparam logic [AddrW-1:0]  RstExtHostA = 32'h0A09_0005;
  localparam logic [AddrW-1:0]  RstExtHostB = 32'h0A09_0001;
  localparam logic [PortW-1:0]  RstAllowPort = 16'd23;
  localparam logic [CountW-1:0] RstSynLimit = 3'd3;

  typedef struct packed {
    logic [AddrW-1:0]  int_host_a;
    logic [AddrW-1:0]  int_host_b;
    logic [AddrW-1:0]  int_host_c;
    logic [AddrW-1:0]  ext_host_a;
    logic [AddrW-1:0]  ext_host_b;
    logic [PortW-1:0]  allowed_port;
    logic [CountW-1:0] syn_limit;
  } hppf_cfg_t;

endpackage

// File: src/hppf_cfg.sv
module hppf_cfg (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_we_i,
  input  logic [hppf_pkg::CfgIdxW-1:0]     cfg_index_i,
  input  logic [hppf_pkg::CfgDataW-1:0]    cfg_data_i,
  output hppf_pkg::hppf_cfg_t              cfg_o
);

  hppf_pkg::hppf_cfg_t cfg_q, cfg_d;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      case (cfg_index_i)
        hppf_pkg::CfgIntHostA:  cfg_d.int_host_a = cfg_data_i;
        hppf_pkg::CfgIntHostB:  cfg_d.int_host_b = cfg_data_i;
        hppf_pkg::CfgIntHostC:  cfg_d.int_host_c = cfg_data_i;
        hppf_pkg::CfgExtHostA:  cfg_d.ext_host_a = cfg_data_i;
        hppf_pkg::CfgExtHostB:  cfg_d.ext_host_b = cfg_data_i;
        hppf_pkg::CfgAllowPort: cfg_d.allowed_port = cfg_data_i[hppf_pkg::PortW-1:0];
        hppf_pkg::CfgSynLimit:  cfg_d.syn_limit = cfg_data_i[hppf_pkg::CountW-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.int_host_a   <= hppf_pkg::RstIntHostA;
      cfg_q.int_host_b   <= hppf_pkg::RstIntHostB;
      cfg_q.int_host_c   <= hppf_pkg::RstIntHostC;
      cfg_q.ext_host_a   <= hppf_pkg::RstExtHostA;
      cfg_q.ext_host_b   <= hppf_pkg::RstExtHostB;
      cfg_q.allowed_port <= hppf_pkg::RstAllowPort;
      cfg_q.syn_limit    <= hppf_pkg::RstSynLimit;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

// File: src/hppf_match.sv
module hppf_match (
  input  hppf_pkg::hppf_cfg_t              cfg_i,
  input  logic [hppf_pkg::AddrW-1:0]       src_i,
  input  logic [hppf_pkg::AddrW-1:0]       dst_i,
  input  logic [hppf_pkg::ProtoW-1:0]      proto_i,
  input  logic [hppf_pkg::PortW-1:0]       port_i,
  output logic                             drop_o
);

  logic src_int, dst_int, src_ext, dst_ext;
  logic pair, allowed;

  always_comb begin
    src_int = (src_i == cfg_i.int_host_a) || (src_i == cfg_i.int_host_b) ||
              (src_i == cfg_i.int_host_c);
    dst_int = (dst_i == cfg_i.int_host_a) || (dst_i == cfg_i.int_host_b) ||
              (dst_i == cfg_i.int_host_c);
    src_ext = (src_i == cfg_i.ext_host_a) || (src_i == cfg_i.ext_host_b);
    dst_ext = (dst_i == cfg_i.ext_host_a) || (dst_i == cfg_i.ext_host_b);
    // Any internal/external pairing in either direction counts.
    pair    = (src_int && dst_ext) || (src_ext && dst_int);
    allowed = (proto_i == hppf_pkg::ProtoTcp) && (port_i == cfg_i.allowed_port);
    drop_o  = pair && !allowed;
  end

endmodule

// File: src/hppf_syn.sv
module hppf_syn (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             update_i,
  input  hppf_pkg::hppf_cfg_t              cfg_i,
  input  logic [hppf_pkg::AddrW-1:0]       src_i,
  input  logic                             syn_i,
  input  logic                             pair_drop_i,
  output logic                             verdict_o
);

  logic [hppf_pkg::CountW-1:0] cnt0_q, cnt0_d, cnt1_q, cnt1_d;
  logic hit0, hit1, drop0, drop1;

  always_comb begin
    cnt0_d = cnt0_q;
    cnt1_d = cnt1_q;
    drop0  = 1'b0;
    drop1  = 1'b0;
    hit0   = !pair_drop_i && syn_i && (src_i == cfg_i.ext_host_a);
    hit1   = !pair_drop_i && syn_i && (src_i == cfg_i.ext_host_b);
    if (hit0) begin
      if (cnt0_q > cfg_i.syn_limit) begin
        drop0 = 1'b1;
      end else if (cnt0_q < hppf_pkg::CountMax) begin
        cnt0_d = cnt0_q + 1'b1;
      end
    end
    // Counter one is consulted only when counter zero did not drop.
    if (hit1 && !drop0) begin
      if (cnt1_q > cfg_i.syn_limit) begin
        drop1 = 1'b1;
      end else if (cnt1_q < hppf_pkg::CountMax) begin
        cnt1_d = cnt1_q + 1'b1;
      end
    end
    verdict_o = pair_drop_i || drop0 || drop1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt0_q <= '0;
      cnt1_q <= '0;
    end else if (update_i) begin
      cnt0_q <= cnt0_d;
      cnt1_q <= cnt1_d;
    end
  end

endmodule

// File: src/host_pair_packet_filter_syn_limit.sv
// Channel   Handshake                Payload
// in        in_valid_i/in_ready_o    source_address_i, dest_address_i, protocol_number_i,
//                                    dest_port_i, syn_flag_i
// out       out_valid_o/out_ready_i  verdict_o
// cfg       cfg_we_i (no wait)       cfg_index_i, cfg_data_i
//
// One packet per cycle while the output is not stalled; the verdict follows the input
// transfer through both stages. Stage one registers the header, stage two holds the
// verdict; the host compares and the SYN counter update sit between them.
// Reset restores the register defaults and clears both SYN counters.
// A stalled output holds both stages; an empty input stage still takes a packet.
module host_pair_packet_filter_syn_limit (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             in_valid_i,
  output logic                             in_ready_o,
  input  logic [hppf_pkg::AddrW-1:0]       source_address_i,
  input  logic [hppf_pkg::AddrW-1:0]       dest_address_i,
  input  logic [hppf_pkg::ProtoW-1:0]      protocol_number_i,
  input  logic [hppf_pkg::PortW-1:0]       dest_port_i,
  input  logic                             syn_flag_i,
  output logic                             out_valid_o,
  input  logic                             out_ready_i,
  output logic                             verdict_o,
  input  logic                             cfg_we_i,
  input  logic [hppf_pkg::CfgIdxW-1:0]     cfg_index_i,
  input  logic [hppf_pkg::CfgDataW-1:0]    cfg_data_i
);

  hppf_pkg::hppf_cfg_t cfg;

  logic                        s1_valid_q;
  logic [hppf_pkg::AddrW-1:0]  src_q;
  logic [hppf_pkg::AddrW-1:0]  dst_q;
  logic [hppf_pkg::ProtoW-1:0] proto_q;
  logic [hppf_pkg::PortW-1:0]  port_q;
  logic                        syn_q;

  logic out_valid_q, verdict_q, verdict_d;
  logic pair_drop, advance, s1_fire;

  // The verdict stage can take a new result when it is empty or being drained.
  assign advance    = !out_valid_q || out_ready_i;
  assign s1_fire    = s1_valid_q && advance;
  assign in_ready_o = !s1_valid_q || advance;

  hppf_cfg u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cfg_o       (cfg)
  );

  hppf_match u_match (
    .cfg_i   (cfg),
    .src_i   (src_q),
    .dst_i   (dst_q),
    .proto_i (proto_q),
    .port_i  (port_q),
    .drop_o  (pair_drop)
  );

  hppf_syn u_syn (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .update_i    (s1_fire),
    .cfg_i       (cfg),
    .src_i       (src_q),
    .syn_i       (syn_q),
    .pair_drop_i (pair_drop),
    .verdict_o   (verdict_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (in_ready_o) begin
        s1_valid_q <= in_valid_i;
      end
      if (advance) begin
        out_valid_q <= s1_valid_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      src_q   <= source_address_i;
      dst_q   <= dest_address_i;
      proto_q <= protocol_number_i;
      port_q  <= dest_port_i;
      syn_q   <= syn_flag_i;
    end
    if (s1_fire) begin
      verdict_q <= verdict_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign verdict_o   = verdict_q;

endmodule

// File: tb/host_pair_packet_filter_syn_limit_tb.sv
module host_pair_packet_filter_syn_limit_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic VerdictAccept = 1'b0;
  localparam logic VerdictDrop   = 1'b1;
  localparam logic [hppf_pkg::ProtoW-1:0] ProtoUdp = 8'd17;

  localparam int unsigned NumRows       = 25;
  localparam int unsigned NumPhases     = 8;
  localparam int unsigned ItemsPerPhase = 150;
  localparam int unsigned MaxGap        = 8;
  localparam int unsigned CycleLimit    = 200000;
  localparam int unsigned MaxReports    = 10;

  typedef enum logic [1:0] {RowByModel, RowTyped, RowConfig} row_kind_e;
  typedef enum logic [1:0] {IdleNone, IdleSender, IdleReceiver, IdleBoth} idle_mode_e;

  typedef struct packed {
    logic [hppf_pkg::AddrW-1:0]  src;
    logic [hppf_pkg::AddrW-1:0]  dst;
    logic [hppf_pkg::ProtoW-1:0] proto;
    logic [hppf_pkg::PortW-1:0]  port;
    logic                        syn;
  } header_t;

  typedef struct packed {
    row_kind_e                     kind;
    header_t                       hdr;
    logic                          verdict;
    logic [hppf_pkg::CfgIdxW-1:0]  idx;
    logic [hppf_pkg::CfgDataW-1:0] data;
  } stim_row_t;

  logic                          clk_i = 1'b0;
  logic                          rst_ni = 1'b0;
  logic                          in_valid_i = 1'b0;
  logic                          in_ready_o;
  logic [hppf_pkg::AddrW-1:0]    source_address_i = '0;
  logic [hppf_pkg::AddrW-1:0]    dest_address_i = '0;
  logic [hppf_pkg::ProtoW-1:0]   protocol_number_i = '0;
  logic [hppf_pkg::PortW-1:0]    dest_port_i = '0;
  logic                          syn_flag_i = 1'b0;
  logic                          out_valid_o;
  logic                          out_ready_i = 1'b0;
  logic                          verdict_o;
  logic                          cfg_we_i = 1'b0;
  logic [hppf_pkg::CfgIdxW-1:0]  cfg_index_i = '0;
  logic [hppf_pkg::CfgDataW-1:0] cfg_data_i = '0;

  host_pair_packet_filter_syn_limit dut (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .in_valid_i        (in_valid_i),
    .in_ready_o        (in_ready_o),
    .source_address_i  (source_address_i),
    .dest_address_i    (dest_address_i),
    .protocol_number_i (protocol_number_i),
    .dest_port_i       (dest_port_i),
    .syn_flag_i        (syn_flag_i),
    .out_valid_o       (out_valid_o),
    .out_ready_i       (out_ready_i),
    .verdict_o         (verdict_o),
    .cfg_we_i          (cfg_we_i),
    .cfg_index_i       (cfg_index_i),
    .cfg_data_i        (cfg_data_i)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // Shadow copy of the filter registers and SYN counters.
  logic [hppf_pkg::AddrW-1:0]  inner_host [3] = '{hppf_pkg::RstIntHostA, hppf_pkg::RstIntHostB,
                                                  hppf_pkg::RstIntHostC};
  logic [hppf_pkg::AddrW-1:0]  outer_host [2] = '{hppf_pkg::RstExtHostA, hppf_pkg::RstExtHostB};
  logic [hppf_pkg::PortW-1:0]  open_port = hppf_pkg::RstAllowPort;
  logic [hppf_pkg::CountW-1:0] syn_ceiling = hppf_pkg::RstSynLimit;
  logic [hppf_pkg::CountW-1:0] syn_seen [2] = '{'0, '0};

  logic        verdict_q [$];
  int unsigned n_sent = 0;
  int unsigned n_done = 0;
  int unsigned n_errors = 0;
  int unsigned cycles = 0;
  int unsigned send_idle_pct = 0;
  int unsigned recv_stall_pct = 0;

  stim_row_t dir_rows [NumRows];
  logic [hppf_pkg::CountW-1:0] phase_limit [NumPhases] =
    '{3'd0, 3'd2, 3'd1, 3'd5, 3'd3, 3'd6, 3'd7, 3'd4};

  function automatic logic filter_verdict(input header_t h);
    logic pair;
    logic drop;
    pair = 1'b0;
    for (int i = 0; i < 3; i++) begin
      for (int j = 0; j < 2; j++) begin
        if ((h.src == inner_host[i] && h.dst == outer_host[j]) ||
            (h.src == outer_host[j] && h.dst == inner_host[i])) begin
          pair = 1'b1;
        end
      end
    end
    drop = pair && !(h.proto == hppf_pkg::ProtoTcp && h.port == open_port);
    // With both externals equal, counter zero may step before counter one drops.
    if (!drop && h.syn) begin
      for (int j = 0; j < 2; j++) begin
        if (!drop && h.src == outer_host[j]) begin
          if (syn_seen[j] > syn_ceiling) begin
            drop = 1'b1;
          end else if (syn_seen[j] != hppf_pkg::CountMax) begin
            syn_seen[j] = syn_seen[j] + 1'b1;
          end
        end
      end
    end
    return drop ? VerdictDrop : VerdictAccept;
  endfunction

  function automatic stim_row_t pkt_row(input row_kind_e kind,
                                        input logic [hppf_pkg::AddrW-1:0] src,
                                        input logic [hppf_pkg::AddrW-1:0] dst,
                                        input logic [hppf_pkg::ProtoW-1:0] proto,
                                        input logic [hppf_pkg::PortW-1:0] port,
                                        input logic syn,
                                        input logic verdict);
    stim_row_t r;
    r = '0;
    r.kind = kind;
    r.hdr = '{src: src, dst: dst, proto: proto, port: port, syn: syn};
    r.verdict = verdict;
    return r;
  endfunction

  function automatic stim_row_t cfg_row(input logic [hppf_pkg::CfgIdxW-1:0] idx,
                                        input logic [hppf_pkg::CfgDataW-1:0] data);
    stim_row_t r;
    r = '0;
    r.kind = RowConfig;
    r.idx = idx;
    r.data = data;
    return r;
  endfunction

  function automatic header_t random_header();
    header_t h;
    int unsigned pick;
    int unsigned i;
    int unsigned j;
    pick = $urandom_range(99);
    i = $urandom_range(2);
    j = $urandom_range(1);
    h.src = $urandom();
    h.dst = $urandom();
    h.proto = hppf_pkg::ProtoW'($urandom());
    h.port = hppf_pkg::PortW'($urandom());
    h.syn = 1'($urandom());
    if (pick < 70) begin
      // Traffic between a listed pair, mostly to the open TCP port.
      if ($urandom_range(1) == 1) begin
        h.src = inner_host[i];
        h.dst = outer_host[j];
      end else begin
        h.src = outer_host[j];
        h.dst = inner_host[i];
      end
      if ($urandom_range(4) != 0) h.proto = hppf_pkg::ProtoTcp;
      if ($urandom_range(4) != 0) h.port = open_port;
    end else if (pick < 85) begin
      h.src = outer_host[j];
      h.syn = 1'b1;
      if ($urandom_range(1) == 1) h.proto = hppf_pkg::ProtoTcp;
    end
    return h;
  endfunction

  function automatic logic [hppf_pkg::AddrW-1:0] pick_addr();
    case ($urandom_range(5))
      0: return '0;
      1: return '1;
      default: return $urandom();
    endcase
  endfunction

  function automatic void set_mode(input idle_mode_e m);
    case (m)
      IdleNone: begin
        send_idle_pct = 0;
        recv_stall_pct = 0;
      end
      IdleSender: begin
        send_idle_pct = 58;
        recv_stall_pct = 0;
      end
      IdleReceiver: begin
        send_idle_pct = 0;
        recv_stall_pct = 58;
      end
      default: begin
        send_idle_pct = 21;
        recv_stall_pct = 21;
      end
    endcase
  endfunction

  task automatic write_reg(input logic [hppf_pkg::CfgIdxW-1:0] idx,
                           input logic [hppf_pkg::CfgDataW-1:0] data);
    cfg_we_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= data;
    case (idx)
      hppf_pkg::CfgIntHostA:  inner_host[0] = data;
      hppf_pkg::CfgIntHostB:  inner_host[1] = data;
      hppf_pkg::CfgIntHostC:  inner_host[2] = data;
      hppf_pkg::CfgExtHostA:  outer_host[0] = data;
      hppf_pkg::CfgExtHostB:  outer_host[1] = data;
      hppf_pkg::CfgAllowPort: open_port = data[hppf_pkg::PortW-1:0];
      hppf_pkg::CfgSynLimit:  syn_ceiling = data[hppf_pkg::CountW-1:0];
      default: ;
    endcase
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic send_header(input header_t h, input logic typed, input logic typed_verdict);
    int unsigned gap;
    logic predicted;
    gap = 0;
    while (gap < MaxGap && $urandom_range(99) < send_idle_pct) gap++;
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    source_address_i <= h.src;
    dest_address_i <= h.dst;
    protocol_number_i <= h.proto;
    dest_port_i <= h.port;
    syn_flag_i <= h.syn;
    do @(posedge clk_i); while (!in_ready_o);
    // The model runs on every accepted transfer, typed rows included, so its counters stay in step.
    predicted = filter_verdict(h);
    verdict_q.push_back(typed ? typed_verdict : predicted);
    n_sent++;
  endtask

  task automatic wait_idle();
    in_valid_i <= 1'b0;
    while (n_done < n_sent) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  always @(posedge clk_i) begin
    out_ready_i <= ($urandom_range(99) >= recv_stall_pct);
  end

  always @(posedge clk_i) begin
    logic want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      n_done++;
      if (verdict_q.size() == 0) begin
        n_errors++;
        if (n_errors <= MaxReports) begin
          $display("unexpected verdict %0b with nothing outstanding", verdict_o);
        end
      end else begin
        want = verdict_q.pop_front();
        if (verdict_o !== want) begin
          n_errors++;
          if (n_errors <= MaxReports) begin
            $display("verdict mismatch at transfer %0d: expected %0b, got %0b",
                     n_done, want, verdict_o);
          end
        end
      end
    end
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles >= CycleLimit) begin
      $display("host_pair_packet_filter_syn_limit_tb: errors");
      $finish;
    end
  end

  initial begin
    logic [hppf_pkg::AddrW-1:0] addr_set [5];
    logic [hppf_pkg::PortW-1:0] port_set;

    dir_rows[0]  = pkt_row(RowTyped, hppf_pkg::RstExtHostA, hppf_pkg::RstIntHostA,
                           hppf_pkg::ProtoTcp, 16'd23, 1'b0, VerdictAccept);
    dir_rows[1]  = pkt_row(RowTyped, hppf_pkg::RstExtHostA, hppf_pkg::RstIntHostA,
                           hppf_pkg::ProtoTcp, 16'd22, 1'b0, VerdictDrop);
    dir_rows[2]  = pkt_row(RowTyped, hppf_pkg::RstIntHostB, hppf_pkg::RstExtHostB,
                           ProtoUdp, 16'd23, 1'b0, VerdictDrop);
    dir_rows[3]  = pkt_row(RowTyped, hppf_pkg::RstIntHostC, hppf_pkg::RstExtHostA,
                           hppf_pkg::ProtoTcp, 16'd23, 1'b1, VerdictAccept);
    dir_rows[4]  = pkt_row(RowTyped, '0, '0, '0, '0, 1'b0, VerdictAccept);
    dir_rows[5]  = pkt_row(RowTyped, '1, '1, '1, '1, 1'b1, VerdictAccept);
    // Four SYNs take counter zero past the reset limit, then the next ones drop.
    for (int k = 6; k < 10; k++) begin
      dir_rows[k] = pkt_row(RowTyped, hppf_pkg::RstExtHostA, 32'h0102_0304,
                            hppf_pkg::ProtoTcp, 16'd80, 1'b1, VerdictAccept);
    end
    for (int k = 10; k < 12; k++) begin
      dir_rows[k] = pkt_row(RowTyped, hppf_pkg::RstExtHostA, 32'h0102_0304,
                            hppf_pkg::ProtoTcp, 16'd80, 1'b1, VerdictDrop);
    end
    // A SYN counts even on a non-TCP packet.
    dir_rows[12] = pkt_row(RowByModel, hppf_pkg::RstExtHostB, 32'h0808_0808, ProtoUdp,
                           16'd53, 1'b1, VerdictAccept);
    dir_rows[13] = pkt_row(RowTyped, hppf_pkg::RstExtHostB, hppf_pkg::RstIntHostA, ProtoUdp,
                           16'd23, 1'b1, VerdictDrop);
    dir_rows[14] = pkt_row(RowByModel, hppf_pkg::RstExtHostB, hppf_pkg::RstIntHostA,
                           hppf_pkg::ProtoTcp, 16'd23, 1'b1, VerdictAccept);
    dir_rows[15] = pkt_row(RowTyped, hppf_pkg::RstExtHostA, 32'h0102_0304,
                           hppf_pkg::ProtoTcp, 16'd80, 1'b0, VerdictAccept);
    // Both externals equal, then a limit of seven where the counter holds.
    dir_rows[16] = cfg_row(hppf_pkg::CfgExtHostB, hppf_pkg::RstExtHostA);
    dir_rows[17] = cfg_row(hppf_pkg::CfgSynLimit, 32'd7);
    for (int k = 18; k < 22; k++) begin
      dir_rows[k] = pkt_row(RowByModel, hppf_pkg::RstExtHostA, 32'h0102_0304,
                            hppf_pkg::ProtoTcp, 16'd443, 1'b1, VerdictAccept);
    end
    dir_rows[22] = cfg_row(hppf_pkg::CfgSynLimit, 32'd5);
    for (int k = 23; k < 25; k++) begin
      dir_rows[k] = pkt_row(RowByModel, hppf_pkg::RstExtHostA, 32'h0102_0304,
                            hppf_pkg::ProtoTcp, 16'd443, 1'b1, VerdictAccept);
    end

    set_mode(IdleBoth);
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    for (int k = 0; k < NumRows; k++) begin
      if (dir_rows[k].kind == RowConfig) begin
        wait_idle();
        write_reg(dir_rows[k].idx, dir_rows[k].data);
      end else begin
        send_header(dir_rows[k].hdr, dir_rows[k].kind == RowTyped, dir_rows[k].verdict);
      end
    end

    for (int p = 0; p < NumPhases; p++) begin
      wait_idle();
      if (p == 0) begin
        addr_set = '{'0, '0, '0, '1, '1};
        port_set = '0;
      end else if (p == 1) begin
        addr_set = '{'1, '1, '1, '0, '0};
        port_set = '1;
      end else begin
        for (int k = 0; k < 5; k++) addr_set[k] = pick_addr();
        port_set = hppf_pkg::PortW'($urandom());
      end
      write_reg(hppf_pkg::CfgIntHostA, addr_set[0]);
      write_reg(hppf_pkg::CfgIntHostB, addr_set[1]);
      write_reg(hppf_pkg::CfgIntHostC, addr_set[2]);
      write_reg(hppf_pkg::CfgExtHostA, addr_set[3]);
      write_reg(hppf_pkg::CfgExtHostB, addr_set[4]);
      // Upper data bits are random; only the register's own width counts.
      write_reg(hppf_pkg::CfgAllowPort, {16'($urandom()), port_set});
      write_reg(hppf_pkg::CfgSynLimit, {29'($urandom()), phase_limit[p]});
      set_mode(idle_mode_e'(p % 4));
      repeat (ItemsPerPhase) send_header(random_header(), 1'b0, VerdictAccept);
    end

    wait_idle();
    if (verdict_q.size() != 0) begin
      n_errors++;
      $display("%0d verdicts never arrived", verdict_q.size());
    end
    if (n_errors == 0) begin
      $display("host_pair_packet_filter_syn_limit_tb: clean");
    end else begin
      $display("host_pair_packet_filter_syn_limit_tb: errors");
    end
    $finish;
  end

endmodule
